>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Types, constants and the quarter-wave sine table for the channel
// frequency response block.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int MAX_TAPS   = 32;
    localparam int MAX_RX     = 4;
    localparam int MAX_TX     = 4;
    localparam int MAX_SPAN   = 128;
    localparam int TABLE_BITS = 10;
    localparam int QSIZE      = 1 << TABLE_BITS;
    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int AMP_AW     = $clog2(MAX_TAPS * MAX_RX * MAX_TX);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] KIND_DELAY = 2'd0;
    localparam logic [1:0] KIND_AMP   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] CFG_RX_COUNT   = 3'd0;
    localparam logic [2:0] CFG_TX_COUNT   = 3'd1;
    localparam logic [2:0] CFG_TAP_COUNT  = 3'd2;
    localparam logic [2:0] CFG_HALF_SPAN  = 3'd3;
    localparam logic [2:0] CFG_PHASE_STEP = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         tap_index;
        logic [1:0]         rx_index;
        logic [1:0]         tx_index;
        logic [15:0]        delay_ns;
        logic signed [15:0] amp_re;
        logic signed [15:0] amp_im;
        logic signed [7:0]  freq_index;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] resp_re;
        logic signed [23:0] resp_im;
        logic               status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  rx_count;
        logic [2:0]  tx_count;
        logic [5:0]  tap_count;
        logic [7:0]  half_span;
        logic [31:0] phase_step;
    } cfg_t;

    // query handed from front to back
    typedef struct packed {
        logic        ok;
        logic [1:0]  rx;
        logic [1:0]  tx;
        logic [31:0] step_f;
    } query_t;

    // store writes issued by the front
    typedef struct packed {
        logic              dly_we;
        logic              amp_we;
        logic [TAP_W-1:0]  tap;
        logic [AMP_AW-1:0] amp_addr;
        logic [15:0]       delay;
        logic [31:0]       amp;
    } store_wr_t;

    typedef logic [14:0] rom_t [QSIZE];

    localparam logic [63:0] TAYLOR_DIV [8] =
        '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        for (int k = 0; k < QSIZE; k++) begin
            x    = (64'(k) * HALF_PI_Q30 + 64'(QSIZE / 2)) / QSIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v    = (sum + 16384) >>> 15;
            r[k] = (v > 32767) ? 15'h7FFF : v[14:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cfr_front.sv
// ----------------------------------------------------------------------------
// cfr_front
// Input stage: holds one item, applies loads to the stores and checks
// queries, then queues them for the back end.
// ----------------------------------------------------------------------------
module cfr_front
    import cfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  logic      back_idle,
    input  logic      q_pop,
    output logic      q_valid,
    output query_t    q_head,
    output store_wr_t wr
);

    logic     hold_reg;
    in_item_t item_reg;
    query_t   qmem_reg [2];
    logic     wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    logic     done;
    logic     q_push;
    logic     is_load;
    query_t   qn;
    logic [7:0]        span;
    logic signed [9:0] fs, sp;

    assign is_load = (item_reg.kind == KIND_DELAY) || (item_reg.kind == KIND_AMP);
    // loads wait until every earlier query has left the pipeline
    assign q_push = hold_reg && (item_reg.kind == KIND_QUERY) && (cnt_reg != 2'd2);
    always_comb
    begin
        if (!hold_reg)
            done = 1'b0;
        else if (is_load)
            done = back_idle && (cnt_reg == 2'd0);
        else if (item_reg.kind == KIND_QUERY)
            done = cnt_reg != 2'd2;
        else
            done = 1'b1;
    end

    assign full = hold_reg && !done;

    assign span = (cfg.half_span > 8'(MAX_SPAN)) ? 8'(MAX_SPAN) : cfg.half_span;
    assign fs   = 10'(item_reg.freq_index);
    assign sp   = signed'({2'b00, span});

    always_comb
    begin
        qn.rx     = item_reg.rx_index;
        qn.tx     = item_reg.tx_index;
        qn.ok     = ({1'b0, item_reg.rx_index} < cfg.rx_count)
                 && ({1'b0, item_reg.tx_index} < cfg.tx_count)
                 && (fs >= -sp) && (fs < sp);
        qn.step_f = cfg.phase_step * 32'(item_reg.freq_index);
    end

    always_comb
    begin
        wr.dly_we   = hold_reg && done && (item_reg.kind == KIND_DELAY);
        wr.amp_we   = hold_reg && done && (item_reg.kind == KIND_AMP);
        wr.tap      = item_reg.tap_index;
        wr.amp_addr = {item_reg.tap_index, item_reg.tx_index, item_reg.rx_index};
        wr.delay    = item_reg.delay_ns;
        wr.amp      = {item_reg.amp_im, item_reg.amp_re};
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_head  = qmem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                hold_reg <= 1'b1;
            else if (done)
                hold_reg <= 1'b0;
            if (q_push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(q_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            item_reg <= item;
        if (q_push)
            qmem_reg[wp_reg] <= qn;
    end

endmodule

>>> rtl/cfr_back.sv
// ----------------------------------------------------------------------------
// cfr_back
// Tap engine: stores, per-tap rotate and accumulate pipeline, result queue.
// ----------------------------------------------------------------------------
module cfr_back
    import cfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  store_wr_t wr,
    input  logic      q_valid,
    input  query_t    q_head,
    output logic      q_pop,
    output logic      back_idle,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

    localparam rom_t SINE_ROM = build_rom();

    logic [15:0] dly_mem [MAX_TAPS];
    logic [31:0] amp_mem [MAX_TAPS * MAX_RX * MAX_TX];

    state_t           state_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [1:0]       rx_reg, tx_reg;
    logic [31:0]      stepf_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        l1_reg, l2_reg, l3_reg, l4_reg;
    logic [15:0] d1_reg;
    logic [31:0] a1_reg, a2_reg, a3_reg;
    logic [31:0] th2_reg;
    logic [14:0] sq3_reg, cq3_reg;
    logic        pz3_reg;
    logic [1:0]  qd3_reg;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [23:0] acc_re_reg, acc_im_reg;

    out_item_t  omem_reg [2];
    logic       owp_reg, orp_reg;
    logic [1:0] ocnt_reg;

    logic [5:0] taps;
    logic       last;
    logic       issue;
    logic       start;
    logic [TABLE_BITS-1:0] pos;
    logic signed [15:0] qs, qc, sv, cv;
    logic signed [15:0] ar, ai;
    logic signed [32:0] sre, sim;
    logic signed [17:0] tre, tim;
    logic signed [23:0] nre, nim;
    logic       opush;
    out_item_t  onew;

    assign taps  = (cfg.tap_count > 6'(MAX_TAPS)) ? 6'(MAX_TAPS) : cfg.tap_count;
    assign last  = {1'b0, tap_reg} == (taps - 6'd1);
    assign issue = state_reg == ST_ISSUE;
    // one query at a time, so one free result slot is enough to start
    assign start = (state_reg == ST_IDLE) && q_valid && (ocnt_reg != 2'd2);
    assign q_pop = start;
    assign back_idle = (state_reg == ST_IDLE);

    assign pos = th2_reg[31-2 -: TABLE_BITS];

    always_comb
    begin
        qs = signed'({1'b0, sq3_reg});
        qc = pz3_reg ? 16'sd32767 : signed'({1'b0, cq3_reg});
        case (qd3_reg)
            2'd0:    begin sv = qs;  cv = qc;  end
            2'd1:    begin sv = qc;  cv = -qs; end
            2'd2:    begin sv = -qs; cv = -qc; end
            default: begin sv = -qc; cv = qs;  end
        endcase
        ar = signed'(a3_reg[15:0]);
        ai = signed'(a3_reg[31:16]);
    end

    always_comb
    begin
        sre = 33'(p1_reg) + 33'(p2_reg) + 33'sd16384;
        sim = 33'(p3_reg) - 33'(p4_reg) + 33'sd16384;
        tre = sre[32:15];
        tim = sim[32:15];
        nre = acc_re_reg + 24'(tre);
        nim = acc_im_reg + 24'(tim);
    end

    always_comb
    begin
        opush = 1'b0;
        onew  = '0;
        if (start && (!q_head.ok || (taps == 6'd0)))
        begin
            opush       = 1'b1;
            onew.status = !q_head.ok;
        end
        else if (v4_reg && l4_reg)
        begin
            opush        = 1'b1;
            onew.resp_re = nre;
            onew.resp_im = nim;
        end
    end

    assign empty  = ocnt_reg == 2'd0;
    assign result = omem_reg[orp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            owp_reg   <= 1'b0;
            orp_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    tap_reg <= '0;
                    if (start && q_head.ok && (taps != 6'd0))
                        state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    tap_reg <= tap_reg + 1'b1;
                    if (last)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (v4_reg && l4_reg)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (opush)
                owp_reg <= !owp_reg;
            if (pop && !empty)
                orp_reg <= !orp_reg;
            ocnt_reg <= ocnt_reg + 2'(opush) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.dly_we)
            dly_mem[wr.tap] <= wr.delay;
        if (wr.amp_we)
            amp_mem[wr.amp_addr] <= wr.amp;
        if (start)
        begin
            rx_reg    <= q_head.rx;
            tx_reg    <= q_head.tx;
            stepf_reg <= q_head.step_f;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_re_reg <= nre;
            acc_im_reg <= nim;
        end
        // stage 1: store reads
        d1_reg <= dly_mem[tap_reg];
        a1_reg <= amp_mem[{tap_reg, tx_reg, rx_reg}];
        l1_reg <= last;
        // stage 2: phase
        th2_reg <= stepf_reg * 32'(d1_reg);
        a2_reg  <= a1_reg;
        l2_reg  <= l1_reg;
        // stage 3: table reads
        sq3_reg <= SINE_ROM[pos];
        cq3_reg <= SINE_ROM[TABLE_BITS'(-pos)];
        pz3_reg <= pos == '0;
        qd3_reg <= th2_reg[31:30];
        a3_reg  <= a2_reg;
        l3_reg  <= l2_reg;
        // stage 4: products
        p1_reg <= ar * cv;
        p2_reg <= ai * sv;
        p3_reg <= ai * cv;
        p4_reg <= ar * sv;
        l4_reg <= l3_reg;
        if (opush)
            omem_reg[owp_reg] <= onew;
    end

endmodule

>>> rtl/channel_frequency_response.sv
// ----------------------------------------------------------------------------
// channel_frequency_response
// Frequency response of a tapped-delay-line MIMO channel.
// ----------------------------------------------------------------------------
// Input is a queue: an item beat is taken when push is high and full is low.
// Delay and amplitude loads write the tap stores and give no result; a query
// gives one result. Results are a queue: the oldest sits on result while
// empty is low and is taken when pop is high. Registers on the cfg port
// (cfg_valid/cfg_ready, always ready) are to be written by the user only
// while the block is idle; the block itself does not enforce it. A query
// runs one tap per cycle through a five-stage rotate and accumulate
// pipeline, and a new query starts only once the previous one has drained.
// Queries that fail the index check, or run with zero taps, skip the
// pipeline. A load waits until all earlier queries have finished.
// Reset sets the registers to their defaults and empties both queues; the
// stores hold garbage until loaded. If pop stays low, two results queue up,
// then the back end stops, then the query queue and input register fill and
// full goes high.
// ----------------------------------------------------------------------------
module channel_frequency_response
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      back_idle;
    logic      q_pop;
    logic      q_valid;
    query_t    q_head;
    store_wr_t wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_count   <= 3'd1;
            cfg_reg.tx_count   <= 3'd1;
            cfg_reg.tap_count  <= 6'd1;
            cfg_reg.half_span  <= 8'd25;
            cfg_reg.phase_step <= 32'd386547;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RX_COUNT:   cfg_reg.rx_count   <= cfg_data[2:0];
                CFG_TX_COUNT:   cfg_reg.tx_count   <= cfg_data[2:0];
                CFG_TAP_COUNT:  cfg_reg.tap_count  <= cfg_data[5:0];
                CFG_HALF_SPAN:  cfg_reg.half_span  <= cfg_data[7:0];
                CFG_PHASE_STEP: cfg_reg.phase_step <= cfg_data;
                default: ;
            endcase
        end
    end

    cfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg       (cfg_reg),
        .back_idle (back_idle),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .wr        (wr)
    );

    cfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .wr        (wr),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .back_idle (back_idle),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> tb/channel_frequency_response_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_frequency_response_tb
// Drives loads, queries and register writes into the channel response block
// and checks every result against a cycle-free predictor of the tap sum.
// ----------------------------------------------------------------------------

class resp_scoreboard;
    logic [14:0]    sine_q [cfr_pkg::QSIZE];
    logic [15:0]    tap_delay [cfr_pkg::MAX_TAPS];
    logic [31:0]    tap_amp [cfr_pkg::MAX_TAPS * cfr_pkg::MAX_RX * cfr_pkg::MAX_TX];
    cfr_pkg::cfg_t  cfg;
    cfr_pkg::out_item_t pending_resp [$];
    int             errors;

    function new();
        longint unsigned x, x2, term;
        longint          acc, v;
        for (int k = 0; k < cfr_pkg::QSIZE; k++)
        begin
            x = (longint'(k) * 64'd1686629713 + cfr_pkg::QSIZE / 2) / cfr_pkg::QSIZE;
            x2 = (x * x) >> 30;
            term = x;
            acc = x;
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc < 0)
                acc = 0;
            v = (acc + 16384) >>> 15;
            sine_q[k] = (v > 32767) ? 15'h7fff : v[14:0];
        end
        cfg.rx_count = 3'd1;
        cfg.tx_count = 3'd1;
        cfg.tap_count = 6'd1;
        cfg.half_span = 8'd25;
        cfg.phase_step = 32'd386547;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            cfr_pkg::CFG_RX_COUNT:   cfg.rx_count = data[2:0];
            cfr_pkg::CFG_TX_COUNT:   cfg.tx_count = data[2:0];
            cfr_pkg::CFG_TAP_COUNT:  cfg.tap_count = data[5:0];
            cfr_pkg::CFG_HALF_SPAN:  cfg.half_span = data[7:0];
            cfr_pkg::CFG_PHASE_STEP: cfg.phase_step = data;
            default: ;
        endcase
    endfunction

    function longint quarter_sine(int k);
        return (k >= cfr_pkg::QSIZE) ? 64'sd32767
                                     : longint'(sine_q[k[cfr_pkg::TABLE_BITS-1:0]]);
    endfunction

    function longint round_q15(longint p);
        return (p + 16384) >>> 15;
    endfunction

    function void note_item(cfr_pkg::in_item_t it);
        cfr_pkg::out_item_t r;
        longint             sum_re, sum_im, ar, ai, s, c, span, f;
        logic [31:0]        theta, fu;
        logic [31:0]        a;
        int                 taps, pos;
        bit                 ok;
        if (it.kind == cfr_pkg::KIND_DELAY)
        begin
            tap_delay[it.tap_index] = it.delay_ns;
            return;
        end
        if (it.kind == cfr_pkg::KIND_AMP)
        begin
            tap_amp[{it.tap_index, it.tx_index, it.rx_index}] = {it.amp_im, it.amp_re};
            return;
        end
        if (it.kind != cfr_pkg::KIND_QUERY)
            return;
        span = (cfg.half_span > 8'(cfr_pkg::MAX_SPAN)) ? longint'(cfr_pkg::MAX_SPAN)
                                                       : longint'(cfg.half_span);
        f = longint'(it.freq_index);
        ok = ({1'b0, it.rx_index} < cfg.rx_count) && ({1'b0, it.tx_index} < cfg.tx_count)
             && f >= -span && f < span;
        sum_re = 0;
        sum_im = 0;
        if (ok)
        begin
            fu = {{24{it.freq_index[7]}}, it.freq_index};
            taps = (cfg.tap_count > 6'(cfr_pkg::MAX_TAPS)) ? cfr_pkg::MAX_TAPS
                                                           : int'(cfg.tap_count);
            for (int l = 0; l < taps; l++)
            begin
                a = tap_amp[{5'(l), it.tx_index, it.rx_index}];
                ar = longint'($signed(a[15:0]));
                ai = longint'($signed(a[31:16]));
                theta = cfg.phase_step * fu * {16'd0, tap_delay[5'(l)]};
                pos = int'(theta[29:20]);
                case (theta[31:30])
                    2'd0:
                    begin
                        s = quarter_sine(pos);
                        c = quarter_sine(cfr_pkg::QSIZE - pos);
                    end
                    2'd1:
                    begin
                        s = quarter_sine(cfr_pkg::QSIZE - pos);
                        c = -quarter_sine(pos);
                    end
                    2'd2:
                    begin
                        s = -quarter_sine(pos);
                        c = -quarter_sine(cfr_pkg::QSIZE - pos);
                    end
                    default:
                    begin
                        s = -quarter_sine(cfr_pkg::QSIZE - pos);
                        c = quarter_sine(pos);
                    end
                endcase
                sum_re += round_q15(ar * c + ai * s);
                sum_im += round_q15(ai * c - ar * s);
            end
        end
        r.resp_re = sum_re[23:0];
        r.resp_im = sum_im[23:0];
        r.status = !ok;
        pending_resp.push_back(r);
    endfunction

    function void check_result(cfr_pkg::out_item_t got);
        cfr_pkg::out_item_t exp;
        if (pending_resp.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp = pending_resp.pop_front();
        if (got.resp_re !== exp.resp_re)
        begin
            $display("%0t: resp_re expected %0d got %0d", $time, exp.resp_re, got.resp_re);
            errors++;
        end
        if (got.resp_im !== exp.resp_im)
        begin
            $display("%0t: resp_im expected %0d got %0d", $time, exp.resp_im, got.resp_im);
            errors++;
        end
        if (got.status !== exp.status)
        begin
            $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
            errors++;
        end
    endfunction
endclass

module channel_frequency_response_tb;
    import cfr_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    in_item_t    item = '0;
    logic        empty;
    logic        pop = 0;
    out_item_t   result;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    resp_scoreboard resp_sb = new();
    bit          hold_off = 0;
    bit          burst_mode = 1;

    channel_frequency_response u_dut (.*);

    always #4 clk = ~clk;

    // result side: random stall pattern, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            resp_sb.check_result(result);
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off)
                pop <= 1'b0;
            else
                case ($urandom_range(0, 3))
                    0: pop <= ($urandom_range(0, 4) == 0);
                    1: pop <= 1'b1;
                    default: pop <= 1'($urandom_range(0, 1));
                endcase
        end
    end

    task automatic send_item(in_item_t it);
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        resp_sb.note_item(it);
        @(negedge clk);
        push <= 1'b0;
        @(negedge clk);
    endtask

    task automatic gap();
        int n;
        if (!burst_mode || $urandom_range(0, 7) != 0)
            return;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
    endtask

    // pushes mostly without dropping push between beats; sometimes drops it and may add a gap
    task automatic offer(in_item_t it);
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        resp_sb.note_item(it);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            @(negedge clk);
            gap();
        end
    endtask

    task automatic drain();
        int guard;
        push <= 1'b0;
        guard = 0;
        while (resp_sb.pending_resp.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    // registers change only with no query in flight
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        while (resp_sb.pending_resp.size() != 0)
            @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        resp_sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t rand_load(logic [1:0] kind, int tap);
        in_item_t it;
        it = '0;
        it.kind = kind;
        it.tap_index = 5'(tap);
        it.rx_index = 2'($urandom_range(0, 3));
        it.tx_index = 2'($urandom_range(0, 3));
        it.delay_ns = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 3000));
        it.amp_re = 16'($urandom);
        it.amp_im = 16'($urandom);
        it.freq_index = 8'($urandom);
        return it;
    endfunction

    // fills every store entry so no query reads an unwritten tap
    task automatic load_all();
        in_item_t it;
        for (int t = 0; t < MAX_TAPS; t++)
        begin
            offer(rand_load(KIND_DELAY, t));
            for (int r = 0; r < MAX_RX; r++)
                for (int x = 0; x < MAX_TX; x++)
                begin
                    it = rand_load(KIND_AMP, t);
                    it.rx_index = 2'(r);
                    it.tx_index = 2'(x);
                    offer(it);
                end
        end
    endtask

    function automatic in_item_t query(int rx, int tx, int f);
        in_item_t it;
        it = rand_load(KIND_QUERY, $urandom_range(0, 31));
        it.rx_index = 2'(rx);
        it.tx_index = 2'(tx);
        it.freq_index = 8'(f);
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        int       q;
        repeat (9) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        load_all();
        drain();

        // directed: reset config, then extremes
        send_item(query(0, 0, 0));
        send_item(query(0, 0, -25));
        send_item(query(0, 0, 24));
        send_item(query(0, 0, 25));
        send_item(query(1, 0, 0));
        send_item(query(0, 1, 0));
        it = rand_load(2'd3, 0);
        send_item(it);
        drain();
        write_reg(CFG_RX_COUNT, 4);
        write_reg(CFG_TX_COUNT, 4);
        write_reg(CFG_TAP_COUNT, 32);
        write_reg(CFG_HALF_SPAN, 128);
        write_reg(CFG_PHASE_STEP, 32'hffff_ffff);
        send_item(query(3, 3, -128));
        send_item(query(3, 3, 127));
        send_item(query(0, 3, 1));
        write_reg(CFG_HALF_SPAN, 0);
        send_item(query(0, 0, 0));
        write_reg(CFG_HALF_SPAN, 255);
        write_reg(CFG_TAP_COUNT, 63);
        send_item(query(2, 1, -128));
        write_reg(CFG_TAP_COUNT, 0);
        send_item(query(1, 1, 5));
        write_reg(CFG_RX_COUNT, 7);
        write_reg(CFG_TX_COUNT, 0);
        send_item(query(3, 0, 1));
        drain();

        // random phases with changing settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_RX_COUNT, $urandom_range(0, 7));
            write_reg(CFG_TX_COUNT, $urandom_range(1, 7));
            write_reg(CFG_TAP_COUNT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                             : $urandom_range(1, 8));
            write_reg(CFG_HALF_SPAN, $urandom_range(0, 255));
            write_reg(CFG_PHASE_STEP, (ph == 0) ? 0 : (ph == 1) ? 32'hffff_ffff
                      : (ph % 2) ? 386547 : $urandom);
            burst_mode = (ph % 3 != 0);
            if (ph == 4)
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int i = 0; i < 55; i++)
            begin
                q = $urandom_range(0, 9);
                if (q < 7)
                    it = query($urandom_range(0, 3), $urandom_range(0, 3),
                               int'($signed(8'($urandom))));
                else if (q == 9)
                    it = rand_load(2'd3, $urandom_range(0, 31));
                else
                    it = rand_load(2'($urandom_range(0, 1)), $urandom_range(0, 31));
                offer(it);
            end
            drain();
        end

        if (resp_sb.errors == 0 && resp_sb.pending_resp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
